// ===== src/ips_pkg.sv =====
// Package for the image pixel statistics unit: field widths, capacity and
// datapath widths. No dependencies.
`default_nettype none

package ips_pkg;

    localparam int PIX_W   = 8;
    localparam int CNT_W   = 25;
    localparam int SUM_W   = 32;
    localparam int SQ_W    = 40;
    localparam int MEAN_W  = 16;
    localparam int SD_W    = 15;

    // shared adder/subtractor and its work registers
    localparam int ALU_W   = 64;
    localparam int ROOT_W  = 40;
    localparam int QUO_W   = 40;
    localparam int REM_W   = 44;
    localparam int STEP_W  = 6;
    localparam int FRAC_W  = 8;

    localparam int OUT_DATA_W = 2 * PIX_W + MEAN_W + SD_W + CNT_W;

    localparam logic [CNT_W-1:0] MAX_PIXELS = 25'd16777216;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

endpackage : ips_pkg

`default_nettype wire

// ===== src/image_pixel_statistics_unit.sv =====
// Image pixel statistics unit: min, max, mean and standard deviation of one
// 8-bit grayscale image, with a shared 64-bit adder/subtractor sequencer.
// Depends on ips_pkg.
//
// Slave channel s_*: one pixel per transaction, s_tlast marks the final pixel
// of an image. Other pixels are taken one per cycle while s_tready is high
// and only update the count, sum, sum of squares, min and max.
// On the last pixel s_tready drops and the sequencer runs one 64-bit
// adder/subtractor through shift-add multiplies N*sumsq (25 steps) and
// sum*sum (32 steps), a subtract, a restoring divide for the mean (40 steps),
// a digit-by-digit square root (40 steps) and a second divide for the
// deviation (40 steps). With a free output register the result is loaded
// in the final step, and s_tready returns in the same cycle.
// Master channel m_*: one result transaction per image. A result still
// waiting in the output register holds the sequencer in its final step with
// s_tready low; pixels of the next image are accepted while a result waits,
// up to and including that image's last pixel.
// Pixels beyond the capacity of 2^24 are dropped and flagged in m_tuser.
// Reset clears the accumulators, the output valid and the sequencer.
`default_nettype none

module image_pixel_statistics_unit
    import ips_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] pixel
    input  wire logic                  s_tlast,   // last_pixel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] min_value, [15:8] max_value, [31:16] mean_q8,
    // [46:32] stddev_q8, [71:47] pixel_count
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser    // too_many
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIFF,
        ST_DIV_MEAN,
        ST_SQRT,
        ST_DIV_SD,
        ST_FINISH
    } state_t;

    state_t                 state_reg;

    // accumulators
    logic [CNT_W-1:0]       cnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [PIX_W-1:0]       min_reg;
    logic [PIX_W-1:0]       max_reg;
    logic                   ovf_reg;

    // sequencer work registers
    logic [ALU_W-1:0]       a_reg;
    logic [ALU_W-1:0]       b_reg;
    logic [ALU_W-1:0]       mc_reg;
    logic [SUM_W-1:0]       mp_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [QUO_W-1:0]       q_reg;
    logic [MEAN_W-1:0]      mean_reg;
    logic [STEP_W-1:0]      step_reg;

    // output register
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic                   out_user_reg;

    logic                   in_xact;
    logic [PIX_W-1:0]       pixel;
    logic [2*PIX_W-1:0]     pixel_sq;
    logic                   step_done;

    logic [ALU_W-1:0]       alu_x;
    logic [ALU_W-1:0]       alu_y;
    logic                   alu_sub;
    logic [ALU_W:0]         alu_res;
    logic                   alu_ge;

    logic [REM_W-1:0]       rem_div;
    logic [REM_W-1:0]       rem_sqrt;
    logic [REM_W-1:0]       rem_next;
    logic [QUO_W-1:0]       q_next;
    logic [ROOT_W-1:0]      root_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xact   = s_tvalid && s_tready;
    assign pixel     = s_tdata[PIX_W-1:0];
    assign pixel_sq  = (2*PIX_W)'(pixel) * (2*PIX_W)'(pixel);
    assign step_done = (step_reg == '0);

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // remainder candidates: divide brings down one dividend bit,
    // root brings down two radicand bits
    assign rem_div  = {rem_reg[REM_W-2:0], q_reg[QUO_W-1]};
    assign rem_sqrt = {rem_reg[REM_W-3:0], a_reg[ALU_W-1 -: 2]};

    always_comb
    begin
        unique case (state_reg)
            ST_MUL_A:
            begin
                alu_x   = a_reg;
                alu_y   = mc_reg;
                alu_sub = 1'b0;
            end
            ST_MUL_B:
            begin
                alu_x   = b_reg;
                alu_y   = mc_reg;
                alu_sub = 1'b0;
            end
            ST_DIFF:
            begin
                alu_x   = a_reg;
                alu_y   = b_reg;
                alu_sub = 1'b1;
            end
            ST_DIV_MEAN, ST_DIV_SD:
            begin
                alu_x   = ALU_W'(rem_div);
                alu_y   = ALU_W'(cnt_reg);
                alu_sub = 1'b1;
            end
            ST_SQRT:
            begin
                alu_x   = ALU_W'(rem_sqrt);
                alu_y   = ALU_W'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_x   = '0;
                alu_y   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                   + {{ALU_W{1'b0}}, alu_sub};
    // no borrow on subtract: x >= y
    assign alu_ge  = alu_res[ALU_W];

    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            rem_next = alu_ge ? alu_res[REM_W-1:0] : rem_sqrt;
        end
        else
        begin
            rem_next = alu_ge ? alu_res[REM_W-1:0] : rem_div;
        end
    end

    assign q_next    = {q_reg[QUO_W-2:0], alu_ge};
    assign root_next = {root_reg[ROOT_W-2:0], alu_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            min_reg       <= PIX_MAX;
            max_reg       <= '0;
            ovf_reg       <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            mc_reg        <= '0;
            mp_reg        <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            q_reg         <= '0;
            mean_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            // the final step reloads the output register itself
            if (out_valid_reg && m_tready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xact)
                    begin
                        if (cnt_reg < MAX_PIXELS)
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                            sum_reg <= sum_reg + SUM_W'(pixel);
                            sq_reg  <= sq_reg + SQ_W'(pixel_sq);
                            if (pixel < min_reg)
                            begin
                                min_reg <= pixel;
                            end
                            if (pixel > max_reg)
                            begin
                                max_reg <= pixel;
                            end
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            state_reg <= ST_START;
                        end
                    end
                end

                ST_START:
                begin
                    a_reg     <= '0;
                    mc_reg    <= ALU_W'(sq_reg);
                    mp_reg    <= SUM_W'(cnt_reg);
                    step_reg  <= STEP_W'(CNT_W - 1);
                    state_reg <= ST_MUL_A;
                end

                ST_MUL_A:
                begin
                    if (mp_reg[0])
                    begin
                        a_reg <= alu_res[ALU_W-1:0];
                    end
                    if (step_done)
                    begin
                        b_reg     <= '0;
                        mc_reg    <= ALU_W'(sum_reg);
                        mp_reg    <= sum_reg;
                        step_reg  <= STEP_W'(SUM_W - 1);
                        state_reg <= ST_MUL_B;
                    end
                    else
                    begin
                        mc_reg   <= mc_reg << 1;
                        mp_reg   <= mp_reg >> 1;
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end

                ST_MUL_B:
                begin
                    if (mp_reg[0])
                    begin
                        b_reg <= alu_res[ALU_W-1:0];
                    end
                    mc_reg <= mc_reg << 1;
                    mp_reg <= mp_reg >> 1;
                    if (step_done)
                    begin
                        state_reg <= ST_DIFF;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end

                ST_DIFF:
                begin
                    // variance numerator, clamped at zero
                    a_reg     <= alu_ge ? alu_res[ALU_W-1:0] : '0;
                    q_reg     <= QUO_W'({sum_reg, {FRAC_W{1'b0}}});
                    rem_reg   <= '0;
                    step_reg  <= STEP_W'(QUO_W - 1);
                    state_reg <= ST_DIV_MEAN;
                end

                ST_DIV_MEAN:
                begin
                    q_reg <= q_next;
                    if (step_done)
                    begin
                        mean_reg  <= q_next[MEAN_W-1:0];
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= STEP_W'(ROOT_W - 1);
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        rem_reg  <= rem_next;
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end

                ST_SQRT:
                begin
                    // radicand is a_reg followed by 16 zero bits
                    root_reg <= root_next;
                    a_reg    <= a_reg << 2;
                    if (step_done)
                    begin
                        q_reg     <= QUO_W'(root_next);
                        rem_reg   <= '0;
                        step_reg  <= STEP_W'(QUO_W - 1);
                        state_reg <= ST_DIV_SD;
                    end
                    else
                    begin
                        rem_reg  <= rem_next;
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end

                ST_DIV_SD:
                begin
                    rem_reg  <= rem_next;
                    q_reg    <= q_next;
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {cnt_reg, q_reg[SD_W-1:0], mean_reg,
                                          max_reg, min_reg};
                        out_user_reg  <= ovf_reg;
                        cnt_reg       <= '0;
                        sum_reg       <= '0;
                        sq_reg        <= '0;
                        min_reg       <= PIX_MAX;
                        max_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // every result covers at least one pixel
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1 -: CNT_W] != '0))
        else $error("result with zero pixel count");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[PIX_W-1:0] <= m_tdata[2*PIX_W-1:PIX_W]))
        else $error("result min above max");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after last pixel");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_PIXELS)
        else $error("pixel count beyond capacity");

endmodule : image_pixel_statistics_unit

`default_nettype wire
